// File: rtl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Types and constants shared by the semantic version parser core and its
// per-character step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package svp_pkg;

    localparam int MAX_LENGTH_DEFAULT = 4096;

    localparam int NUM_W = 31;
    localparam int ACC_W = 35;
    localparam int TAG_W = 12;

    localparam logic [NUM_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] COMPONENTS = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // tag flag bit positions
    localparam int MINUS_OPEN = 0;
    localparam int PLUS_OPEN  = 1;
    localparam int MINUS_SEEN = 2;
    localparam int PLUS_SEEN  = 3;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } svp_in_t;

    typedef struct packed {
        logic             success;
        logic [NUM_W-1:0] major_number;
        logic [NUM_W-1:0] minor_number;
        logic [NUM_W-1:0] patch_number;
        logic [TAG_W-1:0] prerelease_start;
        logic [TAG_W-1:0] prerelease_length;
        logic [TAG_W-1:0] build_start;
        logic [TAG_W-1:0] build_length;
    } svp_out_t;

    typedef struct packed {
        logic [1:0]       components_done;
        logic             last_was_dot;
        logic             number_active;
        logic [NUM_W-1:0] number_value;
        logic             number_overflow;
        logic [NUM_W-1:0] major_value;
        logic [NUM_W-1:0] minor_value;
        logic [NUM_W-1:0] patch_value;
        logic [3:0]       tag_flags;
        logic [TAG_W-1:0] prerelease_start;
        logic [TAG_W-1:0] prerelease_length;
        logic [TAG_W-1:0] build_start;
        logic [TAG_W-1:0] build_length;
        logic             failed;
    } svp_state_t;

    localparam svp_state_t STATE_RESET = '0;

endpackage

`default_nettype wire

// File: rtl/svp_char_step.sv
// ----------------------------------------------------------------------------
// svp_char_step
// Combinational parser step: applies one character to the parse state and,
// on the last character, forms the result and returns the state to reset.
// ----------------------------------------------------------------------------
`default_nettype none

module svp_char_step #(
    parameter int MAX_LENGTH = svp_pkg::MAX_LENGTH_DEFAULT
) (
    input  var svp_pkg::svp_state_t             state_cur,
    input  var logic [$clog2(MAX_LENGTH+2)-1:0] pos_cur,
    input  var logic [$clog2(MAX_LENGTH+2)-1:0] minus_start_cur,
    input  var logic [$clog2(MAX_LENGTH+2)-1:0] plus_start_cur,
    input  var svp_pkg::svp_in_t                request,
    output svp_pkg::svp_state_t                 state_next,
    output logic [$clog2(MAX_LENGTH+2)-1:0]     pos_next,
    output logic [$clog2(MAX_LENGTH+2)-1:0]     minus_start_next,
    output logic [$clog2(MAX_LENGTH+2)-1:0]     plus_start_next,
    output svp_pkg::svp_out_t                   result
);

    localparam int POS_W = $clog2(MAX_LENGTH + 2);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_LENGTH);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LENGTH + 1);

    function automatic logic finish_ok(input svp_pkg::svp_state_t st);
        return !st.number_active ||
               (!st.number_overflow && (st.components_done != svp_pkg::COMPONENTS));
    endfunction

    function automatic svp_pkg::svp_state_t finish_st(input svp_pkg::svp_state_t st);
        svp_pkg::svp_state_t r;
        r = st;
        if (st.number_active)
        begin
            case (st.components_done)
                2'd0:    r.major_value = st.number_value;
                2'd1:    r.minor_value = st.number_value;
                2'd2:    r.patch_value = st.number_value;
                default: r.major_value = st.major_value;
            endcase
            r.components_done = st.components_done + 2'd1;
            r.number_active   = 1'b0;
            r.number_value    = '0;
            r.number_overflow = 1'b0;
        end
        return r;
    endfunction

    always_comb
    begin
        svp_pkg::svp_state_t           st;
        logic [POS_W-1:0]              pos;
        logic [POS_W-1:0]              mstart;
        logic [POS_W-1:0]              pstart;
        logic [POS_W-1:0]              len;
        logic [svp_pkg::ACC_W-1:0]     acc;
        logic [3:0]                    digit;
        logic                          bad;
        logic                          str;
        logic                          ok;

        st     = state_cur;
        pos    = pos_cur;
        mstart = minus_start_cur;
        pstart = plus_start_cur;
        len    = '0;
        acc    = '0;
        digit  = 4'(request.character - svp_pkg::CHAR_ZERO);
        bad    = 1'b0;
        ok     = 1'b0;
        str    = (st.components_done == svp_pkg::COMPONENTS) &&
                 !(st.tag_flags[svp_pkg::MINUS_OPEN] || st.tag_flags[svp_pkg::PLUS_OPEN]);

        if (!st.failed)
        begin
            if (pos >= POS_MAX)
            begin
                bad = 1'b1;
            end
            else if (request.character inside {[svp_pkg::CHAR_ZERO:svp_pkg::CHAR_NINE]})
            begin
                if (str)
                begin
                    bad = 1'b1;
                end
                else if (st.components_done != svp_pkg::COMPONENTS)
                begin
                    acc = ({4'b0, st.number_value} << 3) + ({4'b0, st.number_value} << 1)
                        + svp_pkg::ACC_W'(digit);
                    if (acc > svp_pkg::ACC_W'(svp_pkg::VALUE_MAX))
                    begin
                        st.number_overflow = 1'b1;
                        st.number_value    = svp_pkg::VALUE_MAX;
                    end
                    else
                    begin
                        st.number_value = acc[svp_pkg::NUM_W-1:0];
                    end
                    st.number_active = 1'b1;
                    st.last_was_dot  = 1'b0;
                end
            end
            else
            begin
                case (request.character)
                    svp_pkg::CHAR_DOT:
                    begin
                        if (str)
                        begin
                            bad = 1'b1;
                        end
                        else if (st.components_done != svp_pkg::COMPONENTS)
                        begin
                            if ((st.components_done == svp_pkg::COMPONENTS - 2'd1) ||
                                st.last_was_dot || !st.number_active || !finish_ok(st))
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                st = finish_st(st);
                                st.last_was_dot = 1'b1;
                            end
                        end
                    end
                    svp_pkg::CHAR_PLUS:
                    begin
                        if (!finish_ok(st))
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            st = finish_st(st);
                            if ((st.components_done != svp_pkg::COMPONENTS) ||
                                st.tag_flags[svp_pkg::PLUS_SEEN] ||
                                st.tag_flags[svp_pkg::PLUS_OPEN])
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                // plus closes an open pre-release tag
                                if (st.tag_flags[svp_pkg::MINUS_OPEN])
                                begin
                                    len = pos - mstart;
                                    st.prerelease_start  = svp_pkg::TAG_W'(mstart);
                                    st.prerelease_length = svp_pkg::TAG_W'(len);
                                    st.tag_flags[svp_pkg::MINUS_OPEN] = 1'b0;
                                    st.tag_flags[svp_pkg::MINUS_SEEN] = 1'b1;
                                    if (len == '0)
                                    begin
                                        bad = 1'b1;
                                    end
                                end
                                pstart = pos + POS_W'(1);
                                st.tag_flags[svp_pkg::PLUS_OPEN] = 1'b1;
                            end
                        end
                    end
                    svp_pkg::CHAR_MINUS:
                    begin
                        if (!finish_ok(st))
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            st = finish_st(st);
                            if ((st.components_done != svp_pkg::COMPONENTS) ||
                                st.tag_flags[svp_pkg::MINUS_SEEN] ||
                                st.tag_flags[svp_pkg::MINUS_OPEN])
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                // minus closes an open build tag
                                if (st.tag_flags[svp_pkg::PLUS_OPEN])
                                begin
                                    len = pos - pstart;
                                    st.build_start  = svp_pkg::TAG_W'(pstart);
                                    st.build_length = svp_pkg::TAG_W'(len);
                                    st.tag_flags[svp_pkg::PLUS_OPEN] = 1'b0;
                                    st.tag_flags[svp_pkg::PLUS_SEEN] = 1'b1;
                                    if (len == '0)
                                    begin
                                        bad = 1'b1;
                                    end
                                end
                                mstart = pos + POS_W'(1);
                                st.tag_flags[svp_pkg::MINUS_OPEN] = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if ((st.components_done != svp_pkg::COMPONENTS) || str)
                        begin
                            bad = 1'b1;
                        end
                    end
                endcase
            end
            if (bad)
            begin
                st.failed = 1'b1;
            end
        end

        if (pos != POS_LIMIT)
        begin
            pos = pos + POS_W'(1);
        end

        // end of string checks
        if (request.is_last && !st.failed)
        begin
            ok = 1'b1;
            if (st.last_was_dot || !finish_ok(st))
            begin
                ok = 1'b0;
            end
            else
            begin
                st = finish_st(st);
                if (st.tag_flags[svp_pkg::PLUS_OPEN])
                begin
                    len = pos - pstart;
                    st.build_start  = svp_pkg::TAG_W'(pstart);
                    st.build_length = svp_pkg::TAG_W'(len);
                    if (len == '0)
                    begin
                        ok = 1'b0;
                    end
                end
                if (st.tag_flags[svp_pkg::MINUS_OPEN])
                begin
                    len = pos - mstart;
                    st.prerelease_start  = svp_pkg::TAG_W'(mstart);
                    st.prerelease_length = svp_pkg::TAG_W'(len);
                    if (len == '0)
                    begin
                        ok = 1'b0;
                    end
                end
                if (st.components_done != svp_pkg::COMPONENTS)
                begin
                    ok = 1'b0;
                end
            end
        end

        result = '0;
        if (ok)
        begin
            result.success           = 1'b1;
            result.major_number      = st.major_value;
            result.minor_number      = st.minor_value;
            result.patch_number      = st.patch_value;
            result.prerelease_start  = st.prerelease_start;
            result.prerelease_length = st.prerelease_length;
            result.build_start       = st.build_start;
            result.build_length      = st.build_length;
        end

        if (request.is_last)
        begin
            state_next       = svp_pkg::STATE_RESET;
            pos_next         = '0;
            minus_start_next = '0;
            plus_start_next  = '0;
        end
        else
        begin
            state_next       = st;
            pos_next         = pos;
            minus_start_next = mstart;
            plus_start_next  = pstart;
        end
    end

endmodule

`default_nettype wire

// File: rtl/semantic_version_parser_core.sv
// ----------------------------------------------------------------------------
// semantic_version_parser_core
// Streaming parser for MAJOR.MINOR.PATCH[-pre][+build] version strings (tags in either order), one
// character per request, one result per string.
//
// channel   direction  handshake                   payload
// char      in         char_valid / char_ready     char_data   (svp_in_t)
// result    out        result_valid / result_ready result_data (svp_out_t)
//
// one character per cycle sustained unless a waiting result stalls a last character;
// a request is held in the input register, then the step logic updates the parse state
// the result of a string is registered when its last character leaves the input register
// reset clears the parse state and both valid flags; no clearing pass
// a waiting result stalls only a last character, all others keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module semantic_version_parser_core #(
    parameter int MAX_LENGTH = svp_pkg::MAX_LENGTH_DEFAULT
) (
    input  var logic              clk,
    input  var logic              rst_n,
    input  var logic              char_valid,
    output logic                  char_ready,
    input  var svp_pkg::svp_in_t  char_data,
    output logic                  result_valid,
    input  var logic              result_ready,
    output svp_pkg::svp_out_t     result_data
);

    localparam int POS_W = $clog2(MAX_LENGTH + 2);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LENGTH + 1);

    svp_pkg::svp_in_t    in_reg;
    logic                in_valid_reg;
    svp_pkg::svp_state_t state_reg;
    svp_pkg::svp_state_t state_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    minus_start_reg;
    logic [POS_W-1:0]    minus_start_next;
    logic [POS_W-1:0]    plus_start_reg;
    logic [POS_W-1:0]    plus_start_next;
    svp_pkg::svp_out_t   out_reg;
    svp_pkg::svp_out_t   out_next;
    logic                out_valid_reg;
    logic                advance;

    assign advance    = in_valid_reg && !(in_reg.is_last && out_valid_reg && !result_ready);
    assign char_ready = !in_valid_reg || advance;

    svp_char_step #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_step (
        .state_cur        (state_reg),
        .pos_cur          (pos_reg),
        .minus_start_cur  (minus_start_reg),
        .plus_start_cur   (plus_start_reg),
        .request          (in_reg),
        .state_next       (state_next),
        .pos_next         (pos_next),
        .minus_start_next (minus_start_next),
        .plus_start_next  (plus_start_next),
        .result           (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= svp_pkg::STATE_RESET;
            pos_reg         <= '0;
            minus_start_reg <= '0;
            plus_start_reg  <= '0;
        end
        else
        begin
            if (char_ready)
            begin
                in_valid_reg <= char_valid;
            end
            if (advance)
            begin
                state_reg       <= state_next;
                pos_reg         <= pos_next;
                minus_start_reg <= minus_start_next;
                plus_start_reg  <= plus_start_next;
            end
            if (advance && in_reg.is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            in_reg <= char_data;
        end
        if (advance && in_reg.is_last)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // a finished string leaves the parse state at reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.is_last) |=>
            (state_reg == svp_pkg::STATE_RESET) && (pos_reg == '0))
        else $error("parse state not cleared after last character");

    // position counter saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("character position beyond limit");

    // a failed result carries only zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.success) |->
            (result_data.major_number == '0) && (result_data.minor_number == '0) &&
            (result_data.patch_number == '0) && (result_data.prerelease_length == '0) &&
            (result_data.build_length == '0))
        else $error("failed result with nonzero fields");

    // an absent pre-release tag has start zero on success
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.success && (result_data.prerelease_length == '0)) |->
            (result_data.prerelease_start == '0))
        else $error("absent pre-release tag with nonzero start");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for semantic_version_parser_core. Version strings are
// streamed one character per request: a directed set of edge cases (limits,
// overflow, dot and tag errors, stray bytes), then random versions that are
// mostly well formed, some of them mutated, plus raw noise.
// A predictor follows the parse state per accepted character and queues the
// result each last character must give; every result is compared with it.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN = svp_pkg::MAX_LENGTH_DEFAULT;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct {
        int unsigned pos, done, num_val, major, minor, patch;
        int unsigned plus_start, minus_start, build_span, pre_span;
        bit          last_dot, num_active, num_ovf, failed;
        bit [3:0]    flags;
    } parse_state_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              char_valid = 1'b0;
    logic              char_ready;
    svp_pkg::svp_in_t  char_data = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    svp_pkg::svp_out_t result_data;

    svp_pkg::svp_in_t  char_queue [$];
    svp_pkg::svp_out_t expected_results [$];
    logic [7:0]        pending_text [$];
    parse_state_t      ps;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned ready_phase = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned chars_sent = 0;
    int unsigned total_chars = 0;
    int unsigned strings_sent = 0;
    int unsigned results_checked = 0;
    int unsigned valid_versions = 0;

    semantic_version_parser_core #(
        .MAX_LENGTH(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_data(char_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data(result_data)
    );

    always #5 clk = ~clk;

    // parse state predictor

    function automatic void clear_parse();
        ps = '{default: 0};
    endfunction

    function automatic bit finish_number();
        if (!ps.num_active)
            return 1'b1;
        if (ps.num_ovf)
            return 1'b0;
        case (ps.done)
            0: ps.major = ps.num_val;
            1: ps.minor = ps.num_val;
            2: ps.patch = ps.num_val;
            default: return 1'b0;
        endcase
        ps.done++;
        ps.num_active = 1'b0;
        ps.num_val = 0;
        ps.num_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit close_tag(input int open_bit, input int seen_bit,
                                     input int unsigned start,
                                     inout int unsigned span,
                                     input int unsigned at);
        int unsigned len;
        if (!ps.flags[open_bit])
            return 1'b1;
        len = at - start;
        span = ((start & 32'hFFF) << 12) | (len & 32'hFFF);
        ps.flags[open_bit] = 1'b0;
        ps.flags[seen_bit] = 1'b1;
        return len != 0;
    endfunction

    function automatic bit outside_tag();
        return ps.done >= svp_pkg::COMPONENTS &&
               !(ps.flags[svp_pkg::MINUS_OPEN] || ps.flags[svp_pkg::PLUS_OPEN]);
    endfunction

    function automatic bit take_char(input logic [7:0] c, input int unsigned at);
        longint unsigned v;
        if (c >= svp_pkg::CHAR_ZERO && c <= svp_pkg::CHAR_NINE)
        begin
            if (outside_tag())
                return 1'b0;
            if (ps.done >= svp_pkg::COMPONENTS)
                return 1'b1;
            v = 64'(ps.num_val);
            v = v * 10 + 64'(c - svp_pkg::CHAR_ZERO);
            if (v > 64'(svp_pkg::VALUE_MAX))
            begin
                ps.num_ovf = 1'b1;
                v = 64'(svp_pkg::VALUE_MAX);
            end
            ps.num_val = v[31:0];
            ps.num_active = 1'b1;
            ps.last_dot = 1'b0;
            return 1'b1;
        end
        if (c == svp_pkg::CHAR_DOT)
        begin
            if (outside_tag())
                return 1'b0;
            if (ps.done >= svp_pkg::COMPONENTS)
                return 1'b1;
            if (ps.done + 1 == svp_pkg::COMPONENTS || ps.last_dot || !ps.num_active)
                return 1'b0;
            if (!finish_number())
                return 1'b0;
            ps.last_dot = 1'b1;
            return 1'b1;
        end
        if (c == svp_pkg::CHAR_PLUS)
        begin
            if (!finish_number() || ps.done < svp_pkg::COMPONENTS)
                return 1'b0;
            if (ps.flags[svp_pkg::PLUS_SEEN] || ps.flags[svp_pkg::PLUS_OPEN])
                return 1'b0;
            if (!close_tag(svp_pkg::MINUS_OPEN, svp_pkg::MINUS_SEEN, ps.minus_start,
                           ps.pre_span, at))
                return 1'b0;
            ps.plus_start = at + 1;
            ps.flags[svp_pkg::PLUS_OPEN] = 1'b1;
            return 1'b1;
        end
        if (c == svp_pkg::CHAR_MINUS)
        begin
            if (!finish_number() || ps.done < svp_pkg::COMPONENTS)
                return 1'b0;
            if (ps.flags[svp_pkg::MINUS_SEEN] || ps.flags[svp_pkg::MINUS_OPEN])
                return 1'b0;
            if (!close_tag(svp_pkg::PLUS_OPEN, svp_pkg::PLUS_SEEN, ps.plus_start,
                           ps.build_span, at))
                return 1'b0;
            ps.minus_start = at + 1;
            ps.flags[svp_pkg::MINUS_OPEN] = 1'b1;
            return 1'b1;
        end
        if (ps.done < svp_pkg::COMPONENTS)
            return 1'b0;
        return !outside_tag();
    endfunction

    function automatic bit finish_string(input int unsigned end_pos);
        if (ps.last_dot)
            return 1'b0;
        if (!finish_number())
            return 1'b0;
        if (!close_tag(svp_pkg::PLUS_OPEN, svp_pkg::PLUS_SEEN, ps.plus_start,
                       ps.build_span, end_pos) ||
            !close_tag(svp_pkg::MINUS_OPEN, svp_pkg::MINUS_SEEN, ps.minus_start,
                       ps.pre_span, end_pos))
            return 1'b0;
        return ps.done >= svp_pkg::COMPONENTS;
    endfunction

    function automatic bit parse_char(input svp_pkg::svp_in_t item,
                                      output svp_pkg::svp_out_t res);
        bit ok;
        res = '0;
        if (!ps.failed)
        begin
            if (ps.pos >= MAX_LEN)
                ps.failed = 1'b1;
            else if (!take_char(item.character, ps.pos))
                ps.failed = 1'b1;
        end
        if (ps.pos < MAX_LEN + 1)
            ps.pos++;
        if (!item.is_last)
            return 1'b0;
        ok = !ps.failed && finish_string(ps.pos);
        if (ok)
        begin
            res.success = 1'b1;
            res.major_number = ps.major[svp_pkg::NUM_W-1:0];
            res.minor_number = ps.minor[svp_pkg::NUM_W-1:0];
            res.patch_number = ps.patch[svp_pkg::NUM_W-1:0];
            res.prerelease_start = ps.pre_span[23:12];
            res.prerelease_length = ps.pre_span[11:0];
            res.build_start = ps.build_span[23:12];
            res.build_length = ps.build_span[11:0];
        end
        clear_parse();
        return 1'b1;
    endfunction

    // stimulus helpers

    task automatic text_append(input logic [7:0] c);
        pending_text.insert(pending_text.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_append(s[i]);
    endtask

    task automatic add_number();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 19);
        if (r == 0)
            add_text("2147483647");
        else if (r == 1)
            add_text("2147483648");
        else
        begin
            n = (r == 2) ? $urandom_range(10, 12) : $urandom_range(1, 3);
            repeat (n)
                text_append(svp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    function automatic logic [7:0] tag_byte();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return svp_pkg::CHAR_DOT;
            2, 3, 4: return svp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic add_tag(input logic [7:0] mark);
        int unsigned n;
        n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
        text_append(mark);
        repeat (n)
            text_append(tag_byte());
    endtask

    task automatic commit_string();
        svp_pkg::svp_in_t item;
        for (int i = 0; i < pending_text.size(); i++)
        begin
            item.character = pending_text[i];
            item.is_last = (i == pending_text.size() - 1);
            char_queue.insert(char_queue.size(), item);
        end
        pending_text.delete();
        strings_sent++;
    endtask

    task automatic build_random_string();
        int unsigned idx;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                text_append(8'($urandom_range(0, 255)));
            return;
        end
        add_number();
        text_append(svp_pkg::CHAR_DOT);
        add_number();
        text_append(svp_pkg::CHAR_DOT);
        add_number();
        case ($urandom_range(0, 4))
            1: add_tag(svp_pkg::CHAR_MINUS);
            2: add_tag(svp_pkg::CHAR_PLUS);
            3:
            begin
                add_tag(svp_pkg::CHAR_MINUS);
                add_tag(svp_pkg::CHAR_PLUS);
            end
            4:
            begin
                add_tag(svp_pkg::CHAR_PLUS);
                add_tag(svp_pkg::CHAR_MINUS);
            end
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            idx = $urandom_range(0, pending_text.size() - 1);
            case ($urandom_range(0, 3))
                0: pending_text[idx] = 8'($urandom_range(0, 255));
                1: pending_text.insert(idx, svp_pkg::CHAR_DOT);
                2: pending_text.insert(idx, ($urandom_range(0, 1) != 0) ?
                                            svp_pkg::CHAR_PLUS : svp_pkg::CHAR_MINUS);
                default:
                    if (pending_text.size() > 1)
                        pending_text.delete(idx);
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // request driver, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        svp_pkg::svp_out_t res;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                chars_sent++;
                if (parse_char(char_data, res))
                    expected_results.insert(expected_results.size(), res);
            end
            if (!char_valid || char_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    char_valid <= 1'b0;
                end
                else if (char_queue.size() != 0)
                begin
                    char_data <= char_queue[0];
                    char_queue.delete(0);
                    char_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        svp_pkg::svp_out_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    error_count++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("success", 32'(want.success), 32'(result_data.success));
                    check_field("major_number", 32'(want.major_number),
                                32'(result_data.major_number));
                    check_field("minor_number", 32'(want.minor_number),
                                32'(result_data.minor_number));
                    check_field("patch_number", 32'(want.patch_number),
                                32'(result_data.patch_number));
                    check_field("prerelease_start", 32'(want.prerelease_start),
                                32'(result_data.prerelease_start));
                    check_field("prerelease_length", 32'(want.prerelease_length),
                                32'(result_data.prerelease_length));
                    check_field("build_start", 32'(want.build_start),
                                32'(result_data.build_start));
                    check_field("build_length", 32'(want.build_length),
                                32'(result_data.build_length));
                    results_checked++;
                    if (want.success)
                        valid_versions++;
                end
            end
            ready_phase++;
            if (ready_phase[9])
            begin
                result_ready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        string directed_cases [$];
        int unsigned random_chars;
        directed_cases = '{
            "1.2.3", "0.0.0", "2147483647.2147483647.2147483647", "2147483648.0.0",
            "1.2.99999999999", "007.01.0-rc.1+b.5", "1..2.3", "1.2.", "1.2.3.",
            "1.2.3.4", ".1.2.3", "1.2", "5", "1.2.3-", "1.2.3-a-b", "1.2.3+x-y",
            "1.2.3-a+", "1.2.3-a+b+c", "1.2-a", "1.2.3x", "1x.2.3", "1.2.3 ", "+"
        };
        clear_parse();
        foreach (directed_cases[i])
        begin
            add_text(directed_cases[i]);
            commit_string();
        end
        // bytes at both ends of the range inside a tag
        add_text("9.8.7-");
        text_append(8'h00);
        text_append(8'hFF);
        commit_string();

        random_chars = 0;
        while (random_chars < RANDOM_ITEMS)
        begin
            build_random_string();
            random_chars += pending_text.size();
            commit_string();
        end
        total_chars = char_queue.size();

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        while (chars_sent != total_chars || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d strings in %0d characters, %0d results checked, %0d valid versions",
                 strings_sent, chars_sent, results_checked, valid_versions);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
